>>> rtl/bbn_pkg.sv
`default_nettype none

package bbn_pkg;

  localparam int COORD_W     = 32;
  localparam int MAX_VERTS   = 4096;
  localparam int IDX_W       = $clog2(MAX_VERTS);
  localparam int CNT_W       = $clog2(MAX_VERTS + 1);
  localparam int AXES        = 3;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SCALE_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DVD_W       = 2 + 2 * FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(DVD_W);
  localparam int PROD_W      = COORD_W + SCALE_W;
  localparam int SHIFTED_W   = PROD_W - FRAC_BITS;
  localparam int VERT_W      = AXES * COORD_W;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = ((VERT_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VERT_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VERT_W - CNT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FLAT  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DERIVE,
    S_DIV,
    S_DIFF,
    S_PROD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/bbn_ram.sv
`default_nettype none

module bbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/bounding_box_normalizer_top.sv
`default_nettype none

// Channel  Direction  Payload
// in_      slave      tuser: req_type; tdata: x_in, y_in, z_in, vertex_index
// out_     master     tuser: status;   tdata: x_out, y_out, z_out, count_out
//
// Clear, append, unused code and out-of-range read pass through accept and execute only.
// Read with a current scale steps through accept, memory read, difference, multiply, round.
// First read after a clear or append adds an extent pass plus a 35-step
// restoring divider producing the scale, one quotient bit per cycle.
// Reset clears count and control only; the vertex memory is not cleared.
// A result waits in the output register; the next word is accepted meanwhile.
module bounding_box_normalizer_top import bbn_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [REQ_W-1:0]       in_tuser,   // req_type
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // x_in, y_in, z_in, vertex_index, pad
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [STAT_W-1:0]           out_tuser,  // status
  output logic [OUT_TDATA_W-1:0]      out_tdata   // x_out, y_out, z_out, count_out, pad
);

  state_t state_r, state_nxt;

  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [COORD_W-1:0] vin_r [AXES];
  logic [COORD_W-1:0] vin_nxt [AXES];
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               dvalid_r, dvalid_nxt;
  logic               flat_r, flat_nxt;

  logic signed [COORD_W-1:0] min_r [AXES];
  logic signed [COORD_W-1:0] min_nxt [AXES];
  logic signed [COORD_W-1:0] max_r [AXES];
  logic signed [COORD_W-1:0] max_nxt [AXES];
  logic signed [COORD_W-1:0] ctr_r [AXES];
  logic signed [COORD_W-1:0] ctr_nxt [AXES];

  logic [SCALE_W-1:0]   scale_r, scale_nxt;
  logic [COORD_W-1:0]   dvsr_r, dvsr_nxt;
  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [COORD_W-1:0] mag_r [AXES];
  logic [COORD_W-1:0] mag_nxt [AXES];
  logic [AXES-1:0]    neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r [AXES];
  logic [PROD_W-1:0]  prod_nxt [AXES];

  logic               out_tvalid_r, out_tvalid_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [COORD_W-1:0] out_crd_r [AXES];
  logic [COORD_W-1:0] out_crd_nxt [AXES];
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic              ram_we;
  logic [VERT_W-1:0] ram_wdata;
  logic [VERT_W-1:0] ram_rdata;

  logic slot_free;
  logic accept;
  logic in_range;
  logic is_full;

  logic [DIFF_W-1:0]    ext_full [AXES];
  logic [COORD_W-1:0]   ext [AXES];
  logic [COORD_W-1:0]   dmax;
  logic [COORD_W:0]     rem_sh;
  logic [COORD_W:0]     rem_sub;
  logic                 q_bit;
  logic [DVD_W-1:0]     quo_step;
  logic [DIFF_W-1:0]    dif [AXES];
  logic [SHIFTED_W-1:0] p_sh [AXES];
  logic [COORD_W-1:0]   res [AXES];

  assign slot_free = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign in_range  = {1'b0, idx_r} < count_r;
  assign is_full   = count_r == CNT_W'(MAX_VERTS);

  assign ram_wdata = {vin_r[2], vin_r[1], vin_r[0]};

  bbn_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTS)
  ) u_vert_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_r == REQ_READ && in_range) begin
          state_nxt = dvalid_r ? S_DIFF : S_DERIVE;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DERIVE: state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_PROD;
      S_PROD: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ext_full[a] = {max_r[a][COORD_W-1], max_r[a]} - {min_r[a][COORD_W-1], min_r[a]};
      ext[a]      = ext_full[a][COORD_W-1:0];
      dif[a]      = {ram_rdata[a*COORD_W+COORD_W-1], ram_rdata[a*COORD_W +: COORD_W]}
                    - {ctr_r[a][COORD_W-1], ctr_r[a]};
      p_sh[a]     = prod_r[a][PROD_W-1:FRAC_BITS];
      if (neg_r[a]) begin
        if ((|p_sh[a][SHIFTED_W-1:COORD_W])
            || (p_sh[a][COORD_W-1] && (|p_sh[a][COORD_W-2:0]))) begin
          res[a] = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          res[a] = -p_sh[a][COORD_W-1:0];
        end
      end else begin
        if (|p_sh[a][SHIFTED_W-1:COORD_W-1]) begin
          res[a] = {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
          res[a] = p_sh[a][COORD_W-1:0];
        end
      end
    end
    dmax = ext[0];
    if (ext[1] > dmax) begin
      dmax = ext[1];
    end
    if (ext[2] > dmax) begin
      dmax = ext[2];
    end
    rem_sh   = {rem_r, div_cnt_r == DIV_CNT_W'(DVD_W - 1)};
    rem_sub  = rem_sh - {1'b0, dvsr_r};
    q_bit    = rem_sh >= {1'b0, dvsr_r};
    quo_step = {quo_r[DVD_W-2:0], q_bit};
  end

  always_comb begin
    req_nxt        = req_r;
    vin_nxt        = vin_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    dvalid_nxt     = dvalid_r;
    flat_nxt       = flat_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    ctr_nxt        = ctr_r;
    scale_nxt      = scale_r;
    dvsr_nxt       = dvsr_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_cnt_nxt    = div_cnt_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_stat_nxt   = out_stat_r;
    out_crd_nxt    = out_crd_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_tuser;
          for (int a = 0; a < AXES; a++) begin
            vin_nxt[a] = in_tdata[a*COORD_W +: COORD_W];
          end
          idx_nxt = in_tdata[VERT_W +: IDX_W];
        end
      end
      S_EXEC: begin
        if (slot_free && !(req_r == REQ_READ && in_range)) begin
          out_tvalid_nxt = 1'b1;
          out_stat_nxt   = STAT_OK;
          for (int a = 0; a < AXES; a++) begin
            out_crd_nxt[a] = '0;
          end
          out_cnt_nxt = count_r;
          case (req_r)
            REQ_CLEAR: begin
              count_nxt   = '0;
              dvalid_nxt  = 1'b0;
              out_cnt_nxt = '0;
            end
            REQ_APPEND: begin
              if (is_full) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                for (int a = 0; a < AXES; a++) begin
                  if (count_r == '0 || $signed(vin_r[a]) < min_r[a]) begin
                    min_nxt[a] = $signed(vin_r[a]);
                  end
                  if (count_r == '0 || $signed(vin_r[a]) > max_r[a]) begin
                    max_nxt[a] = $signed(vin_r[a]);
                  end
                end
                count_nxt   = count_r + 1'b1;
                out_cnt_nxt = count_r + 1'b1;
                dvalid_nxt  = 1'b0;
              end
            end
            REQ_READ: out_stat_nxt = STAT_RANGE;
            default: out_stat_nxt = STAT_OK;
          endcase
        end
      end
      S_DERIVE: begin
        for (int a = 0; a < AXES; a++) begin
          ctr_nxt[a] = min_r[a] + $signed({1'b0, ext[a][COORD_W-1:1]});
        end
        flat_nxt    = dmax == '0;
        dvsr_nxt    = dmax;
        rem_nxt     = '0;
        quo_nxt     = '0;
        div_cnt_nxt = DIV_CNT_W'(DVD_W - 1);
      end
      S_DIV: begin
        rem_nxt     = q_bit ? rem_sub[COORD_W-1:0] : rem_sh[COORD_W-1:0];
        quo_nxt     = quo_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          dvalid_nxt = 1'b1;
          if (flat_r) begin
            scale_nxt = '0;
          end else if (|quo_step[DVD_W-1:SCALE_W]) begin
            scale_nxt = '1;
          end else begin
            scale_nxt = quo_step[SCALE_W-1:0];
          end
        end
      end
      S_DIFF: begin
        for (int a = 0; a < AXES; a++) begin
          neg_nxt[a] = dif[a][DIFF_W-1];
          mag_nxt[a] = dif[a][DIFF_W-1] ? (-dif[a][COORD_W-1:0]) : dif[a][COORD_W-1:0];
        end
      end
      S_PROD: begin
        for (int a = 0; a < AXES; a++) begin
          prod_nxt[a] = PROD_W'(mag_r[a]) * PROD_W'(scale_r);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_stat_nxt   = flat_r ? STAT_FLAT : STAT_OK;
          out_crd_nxt    = res;
          out_cnt_nxt    = count_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      dvalid_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dvalid_r     <= dvalid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    vin_r      <= vin_nxt;
    idx_r      <= idx_nxt;
    flat_r     <= flat_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    ctr_r      <= ctr_nxt;
    scale_r    <= scale_nxt;
    dvsr_r     <= dvsr_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    out_stat_r <= out_stat_nxt;
    out_crd_r  <= out_crd_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_crd_r[2], out_crd_r[1], out_crd_r[0]};

endmodule

`default_nettype wire
